// ----- src/four_level_page_table_engine_defines.svh -----
// Assertion macros shared by the page-table engine checkers.
// No dependencies; included by the checker file.
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPTE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPTE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fpte_pkg.sv -----
// Types, constants and helpers for the four-level page-table engine.
// No dependencies; used by the engine and its checker.
package fpte_pkg;

  localparam int unsigned TablePagesDefault = 64;
  localparam int unsigned EntriesPerTable   = 512;
  localparam int unsigned IdxW              = $clog2(EntriesPerTable);
  localparam int unsigned EntryW            = 64;
  localparam int unsigned VaW               = 48;
  localparam int unsigned PaW               = 52;
  localparam int unsigned PageShift         = 12;

  localparam int unsigned ShiftL0 = 39;
  localparam int unsigned ShiftL1 = 30;
  localparam int unsigned ShiftL2 = 21;
  localparam int unsigned ShiftL3 = 12;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  localparam logic [EntryW-1:0] PTE_PRESENT  = 64'h1;
  localparam logic [EntryW-1:0] PTE_WRITABLE = 64'h2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNALIGNED  = 3'd1,
    ST_EXISTS     = 3'd2,
    ST_NOT_MAPPED = 3'd3,
    ST_NO_TABLE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [VaW-1:0]    virt_addr;
    logic [PaW-1:0]    phys_page;
    logic [EntryW-1:0] entry_flags;
  } req_t;

  typedef struct packed {
    status_t        status;
    logic [PaW-1:0] phys_result;
    logic           tlb_flush;
  } rsp_t;

  // Table index for one walk level (0 = root).
  function automatic logic [IdxW-1:0] level_index(input logic [VaW-1:0] va,
                                                  input logic [1:0] level);
    logic [IdxW-1:0] idx;
    case (level)
      2'd0:    idx = va[ShiftL0 +: IdxW];
      2'd1:    idx = va[ShiftL1 +: IdxW];
      2'd2:    idx = va[ShiftL2 +: IdxW];
      default: idx = va[ShiftL3 +: IdxW];
    endcase
    return idx;
  endfunction

endpackage

// ----- src/four_level_page_table_engine.sv -----
// Four-level page-table engine: map, unmap or translate one 4 KiB page per
// request. After reset the root table is swept to zero; no request is taken
// during the sweep. A request whose tables already exist is accepted in
// idle, then gets a read and an evaluate step for each of the four levels
// on the single table RAM, and a final step to post the response. Each
// table that a map allocates is cleared first, one RAM write per entry.
// Requests are handled one at a time; the response register lets the next
// request in while the previous response waits.
// Depends on fpte_pkg and fpte_ram.
module four_level_page_table_engine #(
  parameter int unsigned TABLE_PAGES = fpte_pkg::TablePagesDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fpte_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fpte_pkg::rsp_t rsp
);

  localparam int unsigned PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned IdxW  = fpte_pkg::IdxW;
  localparam int unsigned AW    = PW + IdxW;
  localparam int unsigned Depth = TABLE_PAGES * fpte_pkg::EntriesPerTable;
  localparam int unsigned EW    = fpte_pkg::EntryW;
  localparam int unsigned PaW   = fpte_pkg::PaW;
  localparam int unsigned VaW   = fpte_pkg::VaW;
  localparam int unsigned PS    = fpte_pkg::PageShift;

  fpte_pkg::state_t  state, state_next;

  logic [1:0]        op;
  logic [VaW-1:0]    va;
  logic [PaW-1:0]    pa;
  logic [EW-1:0]     flags;
  logic [1:0]        level;
  logic [PW-1:0]     page;
  logic [NW-1:0]     next_free;
  logic [IdxW-1:0]   cnt;
  fpte_pkg::status_t st;
  logic [PaW-1:0]    res;
  logic              flush;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic [IdxW-1:0]   idx;
  logic              present, at_leaf, pool_full, cnt_last, reject, rsp_free;
  logic              is_map, is_unmap, is_xlate;
  fpte_pkg::status_t reject_st;

  fpte_ram #(
    .WIDTH(EW),
    .DEPTH(Depth)
  ) u_table_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign idx       = fpte_pkg::level_index(va, level);
  assign present   = ram_rdata[0];
  assign at_leaf   = (level == 2'd3);
  assign pool_full = (next_free >= NW'(TABLE_PAGES));
  assign cnt_last  = (cnt == IdxW'(fpte_pkg::EntriesPerTable - 1));
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign is_map    = (op == fpte_pkg::OP_MAP);
  assign is_unmap  = (op == fpte_pkg::OP_UNMAP);
  assign is_xlate  = (op == fpte_pkg::OP_XLATE);

  // Requests that finish without a walk.
  always_comb begin
    reject    = 1'b1;
    reject_st = fpte_pkg::ST_OK;
    case (req.opcode)
      fpte_pkg::OP_MAP: begin
        if (req.virt_addr[PS-1:0] != '0 || req.phys_page[PS-1:0] != '0) begin
          reject_st = fpte_pkg::ST_UNALIGNED;
        end else begin
          reject = 1'b0;
        end
      end
      fpte_pkg::OP_UNMAP: begin
        if (req.virt_addr[PS-1:0] != '0) begin
          reject_st = fpte_pkg::ST_UNALIGNED;
        end else begin
          reject = 1'b0;
        end
      end
      fpte_pkg::OP_XLATE: begin
        reject = 1'b0;
      end
      default: begin
        reject = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      fpte_pkg::S_CLEAR: begin
        if (cnt_last) state_next = fpte_pkg::S_IDLE;
      end
      fpte_pkg::S_IDLE: begin
        if (req_valid) state_next = reject ? fpte_pkg::S_RESP : fpte_pkg::S_READ;
      end
      fpte_pkg::S_READ: begin
        state_next = fpte_pkg::S_EVAL;
      end
      fpte_pkg::S_EVAL: begin
        if (at_leaf) begin
          state_next = fpte_pkg::S_RESP;
        end else if (present) begin
          state_next = fpte_pkg::S_READ;
        end else if (!is_map || pool_full) begin
          state_next = fpte_pkg::S_RESP;
        end else begin
          state_next = fpte_pkg::S_ZERO;
        end
      end
      fpte_pkg::S_ZERO: begin
        if (cnt_last) state_next = fpte_pkg::S_READ;
      end
      fpte_pkg::S_RESP: begin
        if (rsp_free) state_next = fpte_pkg::S_IDLE;
      end
      default: begin
        state_next = fpte_pkg::S_IDLE;
      end
    endcase
  end

  // RAM port control.
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {page, idx};
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {page, idx};
    case (state)
      fpte_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {PW'(0), cnt};
      end
      fpte_pkg::S_IDLE: begin
        req_ready = 1'b1;
      end
      fpte_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      fpte_pkg::S_EVAL: begin
        if (!at_leaf) begin
          // link a fresh table into the missing slot
          ram_we    = !present && is_map && !pool_full;
          ram_wdata = (EW'(next_free) << PS) | fpte_pkg::PTE_PRESENT
                      | fpte_pkg::PTE_WRITABLE;
        end else if (is_map) begin
          ram_we    = !present;
          ram_wdata = {{(EW-PaW){1'b0}}, pa[PaW-1:PS], {PS{1'b0}}} | flags
                      | fpte_pkg::PTE_PRESENT;
        end else if (is_unmap) begin
          ram_we = present;
        end
      end
      fpte_pkg::S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {page, cnt};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpte_pkg::S_CLEAR;
      cnt       <= '0;
      next_free <= NW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fpte_pkg::S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        fpte_pkg::S_CLEAR: begin
          cnt <= cnt + 1'b1;
        end
        fpte_pkg::S_EVAL: begin
          if (!at_leaf && !present && is_map && !pool_full) begin
            next_free <= next_free + 1'b1;
            cnt       <= '0;
          end
        end
        fpte_pkg::S_ZERO: begin
          cnt <= cnt + 1'b1;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // Walk datapath and response register.
  always_ff @(posedge clk) begin
    case (state)
      fpte_pkg::S_IDLE: begin
        op    <= req.opcode;
        va    <= req.virt_addr;
        pa    <= req.phys_page;
        flags <= req.entry_flags;
        level <= 2'd0;
        page  <= '0;
        st    <= reject_st;
        res   <= '0;
        flush <= 1'b0;
      end
      fpte_pkg::S_EVAL: begin
        if (!at_leaf) begin
          if (present) begin
            page  <= ram_rdata[PS +: PW];
            level <= level + 2'd1;
          end else if (!is_map) begin
            st <= fpte_pkg::ST_NOT_MAPPED;
          end else if (pool_full) begin
            st <= fpte_pkg::ST_NO_TABLE;
          end else begin
            page <= next_free[PW-1:0];
          end
        end else if (is_map) begin
          if (present) st <= fpte_pkg::ST_EXISTS;
          else flush <= 1'b1;
        end else if (!present) begin
          st <= fpte_pkg::ST_NOT_MAPPED;
        end else if (is_unmap) begin
          flush <= 1'b1;
        end else if (is_xlate) begin
          res <= {ram_rdata[PaW-1:PS], va[PS-1:0]};
        end
      end
      fpte_pkg::S_ZERO: begin
        if (cnt_last) level <= level + 2'd1;
      end
      fpte_pkg::S_RESP: begin
        if (rsp_free) begin
          rsp.status      <= st;
          rsp.phys_result <= res;
          rsp.tlb_flush   <= flush;
        end
      end
      default: begin
        level <= level;
      end
    endcase
  end

endmodule

// ----- src/fpte_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies; instanced by the page-table engine for its table store.
module fpte_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/fpte_checker.sv -----
// Port-level checks for the page-table engine, bound to the top level.
// Depends on fpte_pkg and four_level_page_table_engine_defines.svh.
`include "four_level_page_table_engine_defines.svh"

module fpte_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fpte_pkg::rsp_t rsp
);

  `FPTE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp), "stalled response changed")

  `FPTE_ASSERT_NOW(a_fail_clean, clk, rst,
    rsp_valid && rsp.status != fpte_pkg::ST_OK,
    rsp.phys_result == '0 && !rsp.tlb_flush, "failed request has side results")

  `FPTE_ASSERT_NOW(a_flush_xor_result, clk, rst,
    rsp_valid && rsp.phys_result != '0, !rsp.tlb_flush,
    "translate result together with flush")

  `FPTE_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready,
    "request taken while one is in progress")

endmodule

bind four_level_page_table_engine fpte_checker u_fpte_checker (.*);
